// ===== src/yuv420_to_packed_rgb_yuyv_assert.svh =====
// Assertion macros shared by the conversion block.
// Both take a clock named clk and an active-low reset named rst_n from the using module.
`ifndef YUV420_TO_PACKED_RGB_YUYV_ASSERT_SVH
`define YUV420_TO_PACKED_RGB_YUYV_ASSERT_SVH
`ifndef SYNTH
// Property holds at every edge outside reset.
`define YRP_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("check failed: %m");
// Trigger at one edge implies consequence at the next.
`define YRP_CHECK_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("check failed: %m");
`else
`define YRP_CHECK(label, prop)
`define YRP_CHECK_NEXT(label, trig, cons)
`endif
`endif

// ===== src/yrp_pkg.sv =====
`timescale 1ns / 1ps
package yrp_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int CFG_DIM_RESET  = 4096;
    localparam int CFG_DIM_W      = 13;
    localparam int CFG_IDX_W      = 3;
    localparam int QUEUE_DEPTH    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT = 3'd4;

    localparam logic FMT_RGB32 = 1'b0;
    localparam logic FMT_YUYV  = 1'b1;

    // conversion coefficients
    localparam int COEF_Y   = 37;
    localparam int COEF_RV  = 51;
    localparam int COEF_GU  = 13;
    localparam int COEF_GV  = 26;
    localparam int COEF_BU  = 65;
    localparam int OFFS_R   = -223;
    localparam int OFFS_G   = 135;
    localparam int OFFS_B   = -277;
    localparam int PIX_MAX  = 'hFF;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } in_item_t;

    typedef struct packed {
        logic [31:0] word_first;
        logic [31:0] word_second;
        logic        row_end;
        logic        frame_end;
    } out_item_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
        logic [CFG_DIM_W-1:0] region_width;
        logic [CFG_DIM_W-1:0] region_height;
        logic                 output_format;
    } cfg_t;

    // classified pair handed from front to back
    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       row_end;
        logic       frame_end;
    } conv_t;

endpackage

// ===== src/yuv420_to_packed_rgb_yuyv.sv =====
`timescale 1ns / 1ps
// Channel   Handshake           Payload      Notes
// input     push / full         item         one luma pair, chroma used on even rows
// result    empty / pop         result       two packed words plus row/frame flags
// config    cfg_write           cfg_index    cfg_data, 13 bits, no read-back
//
// One pair per clock sustained while pop keeps up; an accepted pair passes through the front
// stage, queue, product stage and output register on its way to the result ports.
// Throughput is set by the single-port chroma line store and the one-pair-wide datapath.
// Async active-low reset clears counters, handshake state and configuration registers; data
// registers and line store are not cleared. A stalled pop backs up the output register, the
// product stage, the queue and the front stage, then full rises.
module yuv420_to_packed_rgb_yuyv #(
    parameter int MAX_WIDTH  = yrp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = yrp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  yrp_pkg::in_item_t                item,
    output logic                             empty,
    input  logic                             pop,
    output yrp_pkg::out_item_t               result,
    input  logic                             cfg_write,
    input  logic [yrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [yrp_pkg::CFG_DIM_W-1:0]    cfg_data
);
    import yrp_pkg::*;

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    // front-to-queue and queue-to-back transactions
    logic  q_wr, q_full, q_rd, q_empty;
    conv_t q_wr_data, q_rd_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            priority case (cfg_index)
                REG_FRAME_WIDTH:   cfg_next.frame_width   = cfg_data;
                REG_FRAME_HEIGHT:  cfg_next.frame_height  = cfg_data;
                REG_REGION_WIDTH:  cfg_next.region_width  = cfg_data;
                REG_REGION_HEIGHT: cfg_next.region_height = cfg_data;
                REG_OUTPUT_FORMAT: cfg_next.output_format = cfg_data[0];
                default:           cfg_next = cfg_reg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= CFG_DIM_W'(CFG_DIM_RESET);
            cfg_reg.frame_height  <= CFG_DIM_W'(CFG_DIM_RESET);
            cfg_reg.region_width  <= CFG_DIM_W'(CFG_DIM_RESET);
            cfg_reg.region_height <= CFG_DIM_W'(CFG_DIM_RESET);
            cfg_reg.output_format <= FMT_RGB32;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: position tracking, region clamp, chroma line store
    yrp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (q_wr_data)
    );

    // decoupling queue
    yrp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // back: color math and result register
    yrp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .fmt     (cfg_reg.output_format),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .q_data  (q_rd_data),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== src/yrp_front.sv =====
`timescale 1ns / 1ps
`include "yuv420_to_packed_rgb_yuyv_assert.svh"
module yrp_front #(
    parameter int MAX_WIDTH  = yrp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = yrp_pkg::MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  yrp_pkg::cfg_t     cfg,
    input  logic              push,
    output logic              full,
    input  yrp_pkg::in_item_t item,
    input  logic              q_full,
    output logic              q_wr,
    output yrp_pkg::conv_t    q_data
);
    import yrp_pkg::*;

    localparam int LINE_PAIRS = (MAX_WIDTH + 1) / 2;
    localparam int PCW = (LINE_PAIRS > 1) ? $clog2(LINE_PAIRS) : 1;
    localparam int RCW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW  = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ? $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
    localparam int DH  = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ? $clog2(MAX_HEIGHT + 1) : CFG_DIM_W;

    // clamped region, re-derived every cycle from the registers
    logic [CFG_DIM_W-1:0] w_min;
    logic [CFG_DIM_W-1:0] h_min;
    logic [DW-1:0]        w_clamp;
    logic [DH-1:0]        h_clamp;
    logic [DW:0]          w_plus1;
    logic [DW-1:0]        pairs;
    logic [DH-1:0]        height;

    logic [PCW-1:0] col_reg, col_next;
    logic [RCW-1:0] row_reg, row_next;

    logic accept, region_empty, in_range, last_col, last_row, load;

    logic           s1_valid_reg, s1_valid_next;
    logic [7:0]     s1_y0_reg, s1_y1_reg, s1_cb_reg, s1_cr_reg;
    logic           s1_odd_reg, s1_row_end_reg, s1_frame_end_reg;
    logic [15:0]    line_store_reg [LINE_PAIRS];
    logic [15:0]    line_q_reg;

    always_comb
    begin
        w_min   = (cfg.region_width < cfg.frame_width) ? cfg.region_width : cfg.frame_width;
        h_min   = (cfg.region_height < cfg.frame_height) ? cfg.region_height
                                                         : cfg.frame_height;
        w_clamp = (DW'(w_min) < DW'(MAX_WIDTH)) ? DW'(w_min) : DW'(MAX_WIDTH);
        h_clamp = (DH'(h_min) < DH'(MAX_HEIGHT)) ? DH'(h_min) : DH'(MAX_HEIGHT);
        w_plus1 = {1'b0, w_clamp} + (DW+1)'(1);
        pairs   = w_plus1[DW:1];
        height  = h_clamp;
    end

    assign accept       = push && !full;
    assign region_empty = (pairs == '0) || (height == '0);
    assign in_range     = (DW'(col_reg) < pairs) && (DH'(row_reg) < height);
    assign last_col     = (DW'(col_reg) + DW'(1)) == pairs;
    assign last_row     = (DH'(row_reg) + DH'(1)) == height;
    assign load         = accept && !region_empty && in_range;

    // stage moves into the queue whenever there is room
    assign q_wr = s1_valid_reg && !q_full;
    assign full = s1_valid_reg && q_full;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && !region_empty)
        begin
            if (!in_range)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (!last_col)
            begin
                col_next = col_reg + PCW'(1);
            end
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RCW'(1);
            end
        end
        s1_valid_next = load || (s1_valid_reg && q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_y0_reg        <= item.luma_first;
            s1_y1_reg        <= item.luma_second;
            s1_cb_reg        <= item.chroma_blue;
            s1_cr_reg        <= item.chroma_red;
            s1_odd_reg       <= row_reg[0];
            s1_row_end_reg   <= last_col;
            s1_frame_end_reg <= last_col && last_row;
        end
    end

    // chroma line store: written on even rows, read back on odd rows
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (!row_reg[0])
                line_store_reg[col_reg] <= {item.chroma_blue, item.chroma_red};
            else
                line_q_reg <= line_store_reg[col_reg];
        end
    end

    always_comb
    begin
        q_data.y0        = s1_y0_reg;
        q_data.y1        = s1_y1_reg;
        q_data.cb        = s1_odd_reg ? line_q_reg[15:8] : s1_cb_reg;
        q_data.cr        = s1_odd_reg ? line_q_reg[7:0] : s1_cr_reg;
        q_data.row_end   = s1_row_end_reg;
        q_data.frame_end = s1_frame_end_reg;
    end

    `YRP_CHECK(a_no_write_when_full, !(q_wr && q_full))
    `YRP_CHECK_NEXT(a_stall_holds, s1_valid_reg && q_full, s1_valid_reg && $stable(q_data))
    `YRP_CHECK_NEXT(a_col_in_range, load,
                    (pairs != $past(pairs)) || (DW'(col_reg) < pairs))

endmodule

// ===== src/yrp_queue.sv =====
`timescale 1ns / 1ps
module yrp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  yrp_pkg::conv_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output yrp_pkg::conv_t rd_data,
    output logic           empty
);
    import yrp_pkg::*;

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    conv_t           slot_reg [QUEUE_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_wr, do_rd;

    assign full    = count_reg == CNTW'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        count_next = count_reg + CNTW'(do_wr) - CNTW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== src/yrp_back.sv =====
`timescale 1ns / 1ps
module yrp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fmt,
    input  logic               q_empty,
    output logic               q_rd,
    input  yrp_pkg::conv_t     q_data,
    output logic               empty,
    input  logic               pop,
    output yrp_pkg::out_item_t result
);
    import yrp_pkg::*;

    // floor shift, offset, clamp to a byte
    function automatic logic [7:0] chan(input logic signed [16:0] sum,
                                        input logic signed [16:0] offs);
        logic signed [16:0] t;
        t = (sum >>> 5) + offs;
        if (t < 0)
            chan = 8'd0;
        else if (t > 17'sd255)
            chan = 8'(PIX_MAX);
        else
            chan = t[7:0];
    endfunction

    // product stage
    logic        m_valid_reg, m_valid_next;
    logic [13:0] y37a_reg, y37b_reg, v51_reg;
    logic [11:0] u13_reg;
    logic [12:0] v26_reg;
    logic [14:0] u65_reg;
    conv_t       m_item_reg;

    // output register
    logic        o_valid_reg, o_valid_next;
    out_item_t   o_item_reg, o_item_next;

    logic o_ready, m_ready;
    logic signed [16:0] r_a, g_a, b_a, r_b, g_b, b_b;
    logic [7:0] rr_a, gg_a, bb_a, rr_b, gg_b, bb_b;

    assign o_ready = !o_valid_reg || pop;
    assign m_ready = !m_valid_reg || o_ready;
    assign q_rd    = !q_empty && m_ready;
    assign empty   = !o_valid_reg;
    assign result  = o_item_reg;

    always_comb
    begin
        m_valid_next = m_ready ? q_rd : m_valid_reg;
        o_valid_next = o_ready ? m_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            y37a_reg   <= {6'b0, q_data.y0} * 14'(COEF_Y);
            y37b_reg   <= {6'b0, q_data.y1} * 14'(COEF_Y);
            v51_reg    <= {6'b0, q_data.cr} * 14'(COEF_RV);
            u13_reg    <= {4'b0, q_data.cb} * 12'(COEF_GU);
            v26_reg    <= {5'b0, q_data.cr} * 13'(COEF_GV);
            u65_reg    <= {7'b0, q_data.cb} * 15'(COEF_BU);
            m_item_reg <= q_data;
        end
    end

    always_comb
    begin
        r_a = $signed({3'b0, y37a_reg}) + $signed({3'b0, v51_reg});
        g_a = $signed({3'b0, y37a_reg}) - $signed({5'b0, u13_reg}) - $signed({4'b0, v26_reg});
        b_a = $signed({3'b0, y37a_reg}) + $signed({2'b0, u65_reg});
        r_b = $signed({3'b0, y37b_reg}) + $signed({3'b0, v51_reg});
        g_b = $signed({3'b0, y37b_reg}) - $signed({5'b0, u13_reg}) - $signed({4'b0, v26_reg});
        b_b = $signed({3'b0, y37b_reg}) + $signed({2'b0, u65_reg});
        rr_a = chan(r_a, 17'(OFFS_R));
        gg_a = chan(g_a, 17'(OFFS_G));
        bb_a = chan(b_a, 17'(OFFS_B));
        rr_b = chan(r_b, 17'(OFFS_R));
        gg_b = chan(g_b, 17'(OFFS_G));
        bb_b = chan(b_b, 17'(OFFS_B));

        o_item_next.row_end   = m_item_reg.row_end;
        o_item_next.frame_end = m_item_reg.frame_end;
        unique case (fmt)
            FMT_YUYV:
            begin
                o_item_next.word_first  = {m_item_reg.cr, m_item_reg.y1,
                                           m_item_reg.cb, m_item_reg.y0};
                o_item_next.word_second = '0;
            end
            default:
            begin
                o_item_next.word_first  = {8'h00, rr_a, gg_a, bb_a};
                o_item_next.word_second = {8'h00, rr_b, gg_b, bb_b};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (m_valid_reg && o_ready)
            o_item_reg <= o_item_next;
    end

endmodule
